// ----- rtl/sdi_pkg.sv -----
// ----------------------------------------------------------------------------
// sdi_pkg: shared types and constants of the stroke dab interpolator
// Sequencer phases, control and status structs, field widths and the
// fixed reciprocals used by the quotient step.
// ----------------------------------------------------------------------------
package sdi_pkg;

  localparam int POS_W    = 24;
  localparam int PRS_W    = 17;
  localparam int SIZE_W   = 14;
  localparam int VAL_W    = 25;
  localparam int MAG_W    = 24;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 64;
  localparam int D2_W     = 50;
  localparam int R2_W     = 60;
  localparam int RECIP_SH = 31;
  localparam int FLD_W    = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [FLD_W-1:0] FLD_X    = 2'd0;
  localparam logic [FLD_W-1:0] FLD_Y    = 2'd1;
  localparam logic [FLD_W-1:0] FLD_P    = 2'd2;
  localparam logic [FLD_W-1:0] FLD_LAST = FLD_P;

  localparam logic [PRS_W-1:0]  P_ONE      = 17'h10000;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 14'd160;
  localparam logic              REG_SIZE   = 1'b0;

  localparam logic [MUL_W-1:0] RECIP_ONE   = 32'h8000_0000;
  localparam logic [MUL_W-1:0] RECIP_EIGHT = 32'h1000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DX,
    ST_DY,
    ST_RAD,
    ST_RSQ,
    ST_CMP,
    ST_QUO,
    ST_MULN,
    ST_FIX,
    ST_EMIT
  } phase_e;

  typedef struct packed {
    logic             in_ready;
    phase_e           phase;
    logic [FLD_W-1:0] fld;
    logic             emit;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic last_dab;
  } status_t;

endpackage

// ----- rtl/sdi_mul.sv -----
// ----------------------------------------------------------------------------
// sdi_mul: shared unsigned multiplier
// One 32 by 32 bit product, used in turn for squares, radius, reciprocal
// quotients, remainder products and dab radii.
// ----------------------------------------------------------------------------
module sdi_mul
  import sdi_pkg::*;
(
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic [PROD_W-1:0] p_o
);

  assign p_o = PROD_W'(a_i) * PROD_W'(b_i);

endmodule

// ----- rtl/sdi_cfg.sv -----
// ----------------------------------------------------------------------------
// sdi_cfg: configuration register file
// APB-style port holding the brush size register.
// ----------------------------------------------------------------------------
module sdi_cfg
  import sdi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [SIZE_W-1:0] brush_size_o
);

  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] size_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SIZE);

  always_comb begin
    size_d = size_q;
    if (wr_en) begin
      size_d = pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else begin
      size_q <= size_d;
    end
  end

  assign prdata       = (paddr[2] == REG_SIZE) ? DATA_W'(size_q) : '0;
  assign brush_size_o = size_q;

endmodule

// ----- rtl/sdi_ctrl.sv -----
// ----------------------------------------------------------------------------
// sdi_ctrl: segment sequencer
// Steps the datapath through setup products, the dab count decision, the
// per-field quotient and remainder, and the dab emission phase.
// ----------------------------------------------------------------------------
module sdi_ctrl
  import sdi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t sts_i,
  output ctrl_t   ctrl_o
);

  phase_e           state_q;
  phase_e           state_d;
  logic [FLD_W-1:0] fld_q;
  logic [FLD_W-1:0] fld_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DX;
        end
      end
      ST_DX:   state_d = ST_DY;
      ST_DY:   state_d = ST_RAD;
      ST_RAD:  state_d = ST_RSQ;
      ST_RSQ:  state_d = ST_CMP;
      ST_CMP:  state_d = ST_QUO;
      ST_QUO:  state_d = ST_MULN;
      ST_MULN: state_d = ST_FIX;
      ST_FIX: begin
        state_d = (fld_q == FLD_LAST) ? ST_EMIT : ST_QUO;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.last_dab) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    fld_d = fld_q;
    if (state_q == ST_FIX) begin
      fld_d = (fld_q == FLD_LAST) ? FLD_X : fld_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fld_q   <= FLD_X;
    end else begin
      state_q <= state_d;
      fld_q   <= fld_d;
    end
  end

  always_comb begin
    ctrl_o.in_ready = (state_q == ST_IDLE);
    ctrl_o.phase    = state_q;
    ctrl_o.fld      = fld_q;
    ctrl_o.emit     = (state_q == ST_EMIT) && sts_i.out_free;
  end

endmodule

// ----- rtl/stroke_dab_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// An accepted segment first runs the setup phases, using the shared multiplier in DX, DY,
// RAD, RSQ, QUO and MULN, then emits its n dabs (n is 1, 8 or MAX_DABS), one per cycle
// while the output register is free. A new transaction is accepted only once the
// last dab of the segment has entered the output register.
// Asynchronous active-low reset idles the sequencer, empties the output
// register and sets brush_size to 160.
// ----------------------------------------------------------------------------
// stroke_dab_interpolator_top: stroke segment to brush dab interpolator
// Picks the dab count from squared length against squared minimum radius
// and steps position and pressure linearly with exact rounding.
// ----------------------------------------------------------------------------
module stroke_dab_interpolator_top
  import sdi_pkg::*;
#(
  parameter int MAX_DABS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     has_previous_i,
  input  logic signed [POS_W-1:0]  start_x_i,
  input  logic signed [POS_W-1:0]  start_y_i,
  input  logic [PRS_W-1:0]         start_pressure_i,
  input  logic signed [POS_W-1:0]  end_x_i,
  input  logic signed [POS_W-1:0]  end_y_i,
  input  logic [PRS_W-1:0]         end_pressure_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [POS_W-1:0]  dab_x_o,
  output logic signed [POS_W-1:0]  dab_y_o,
  output logic [PRS_W-1:0]         dab_pressure_o,
  output logic [SIZE_W-1:0]        dab_radius_o,
  output logic                     last_o
);

  localparam int NW = $clog2(MAX_DABS + 1);
  localparam logic [NW-1:0]    N_ONE     = NW'(1);
  localparam logic [NW-1:0]    N_EIGHT   = NW'(8);
  localparam logic [NW-1:0]    N_MAX     = NW'(MAX_DABS);
  localparam logic [MUL_W-1:0] RECIP_MAX =
    MUL_W'(((64'd1 << RECIP_SH) + 64'(MAX_DABS) - 64'd1) / 64'(MAX_DABS));

  ctrl_t             ctrl;
  status_t           sts;
  logic [SIZE_W-1:0] brush_size;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  logic [VAL_W-1:0]  s_q [3];
  logic [VAL_W-1:0]  e_q [3];
  logic              hp_q;
  logic [PROD_W-1:0] prod_q;
  logic [D2_W-1:0]   d2_q;
  logic              rz_q;
  logic [NW-1:0]     n_q;
  logic [MUL_W-1:0]  recip_q;
  logic [MAG_W-1:0]  quo_q;
  logic [VAL_W-1:0]  step_q  [3];
  logic [NW-1:0]     stepr_q [3];
  logic [VAL_W-1:0]  val_q   [3];
  logic [NW-1:0]     accr_q  [3];
  logic [NW-1:0]     cnt_q;

  logic                    out_valid_q;
  logic [POS_W-1:0]        out_x_q;
  logic [POS_W-1:0]        out_y_q;
  logic [PRS_W-1:0]        out_p_q;
  logic [SIZE_W-1:0]       out_r_q;
  logic                    out_last_q;

  logic                    accept;
  logic [PRS_W-1:0]        sp_sat;
  logic [PRS_W-1:0]        ep_sat;
  logic [PRS_W-1:0]        minp;
  logic [FLD_W-1:0]        sel;
  logic [VAL_W:0]          diff;
  logic [VAL_W:0]          diff_abs;
  logic                    neg;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        quo_next;
  logic [PROD_W-1:0]       r2;
  logic [PROD_W-1:0]       th_max;
  logic [PROD_W-1:0]       th_eight;
  logic [PROD_W-1:0]       d2_ext;
  logic [NW-1:0]           n_sel;
  logic [MUL_W-1:0]        recip_sel;
  logic [NW-1:0]           rem;
  logic [VAL_W-1:0]        quo_ext;
  logic [VAL_W-1:0]        step_new;
  logic [NW-1:0]           stepr_new;
  logic [NW:0]             rsum   [3];
  logic                    carry  [3];
  logic [VAL_W-1:0]        vnext  [3];
  logic [NW-1:0]           rnext  [3];
  logic [PROD_W-1:0]       rad_sum;

  sdi_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .brush_size_o (brush_size)
  );

  sdi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .ctrl_o     (ctrl)
  );

  sdi_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  assign in_ready_o   = ctrl.in_ready;
  assign accept       = ctrl.in_ready && in_valid_i;
  assign sts.out_free = !out_valid_q || out_ready_i;
  assign sts.last_dab = (cnt_q == NW'(n_q - N_ONE));

  assign sp_sat = (start_pressure_i > P_ONE) ? P_ONE : start_pressure_i;
  assign ep_sat = (end_pressure_i > P_ONE) ? P_ONE : end_pressure_i;
  assign minp   = (s_q[FLD_P][PRS_W-1:0] < e_q[FLD_P][PRS_W-1:0]) ?
                  s_q[FLD_P][PRS_W-1:0] : e_q[FLD_P][PRS_W-1:0];

  always_comb begin
    unique case (ctrl.phase)
      ST_DX:   sel = FLD_X;
      ST_DY:   sel = FLD_Y;
      default: sel = ctrl.fld;
    endcase
  end

  assign diff     = {e_q[sel][VAL_W-1], e_q[sel]} - {s_q[sel][VAL_W-1], s_q[sel]};
  assign neg      = diff[VAL_W];
  assign diff_abs = neg ? (~diff + 1'b1) : diff;
  assign mag      = diff_abs[MAG_W-1:0];
  assign quo_next = prod_q[RECIP_SH +: MAG_W];

  always_comb begin
    unique case (ctrl.phase)
      ST_DX, ST_DY: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(mag);
      end
      ST_RAD: begin
        mul_a = MUL_W'(brush_size);
        mul_b = MUL_W'(minp);
      end
      ST_RSQ: begin
        mul_a = prod_q[MUL_W-1:0];
        mul_b = prod_q[MUL_W-1:0];
      end
      ST_QUO: begin
        mul_a = MUL_W'(mag);
        mul_b = recip_q;
      end
      ST_MULN: begin
        mul_a = MUL_W'(quo_next);
        mul_b = MUL_W'(n_q);
      end
      ST_EMIT: begin
        mul_a = MUL_W'(brush_size);
        mul_b = MUL_W'(vnext[FLD_P][PRS_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign r2       = PROD_W'(prod_q[R2_W-1:0]);
  assign th_max   = ((r2 << 2) + 64'hFF_FFFF) >> 24;
  assign th_eight = (r2 + 64'hFF_FFFF) >> 24;
  assign d2_ext   = PROD_W'(d2_q);

  always_comb begin
    priority if (!hp_q) begin
      n_sel = N_ONE;
    end else if (rz_q) begin
      n_sel = (d2_q != '0) ? N_MAX : N_ONE;
    end else if (d2_ext >= th_max) begin
      n_sel = N_MAX;
    end else if (d2_ext >= th_eight) begin
      n_sel = N_EIGHT;
    end else begin
      n_sel = N_ONE;
    end
  end

  always_comb begin
    priority case (n_sel)
      N_MAX:   recip_sel = RECIP_MAX;
      N_EIGHT: recip_sel = RECIP_EIGHT;
      default: recip_sel = RECIP_ONE;
    endcase
  end

  assign rem     = mag[NW-1:0] - prod_q[NW-1:0];
  assign quo_ext = VAL_W'(quo_q);

  always_comb begin
    priority if (neg && (rem != '0)) begin
      step_new  = ~quo_ext;
      stepr_new = n_q - rem;
    end else if (neg) begin
      step_new  = ~quo_ext + 1'b1;
      stepr_new = '0;
    end else begin
      step_new  = quo_ext;
      stepr_new = rem;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum[k]  = {1'b0, accr_q[k]} + {1'b0, stepr_q[k]};
      carry[k] = (rsum[k] >= {1'b0, n_q});
      vnext[k] = val_q[k] + step_q[k] + VAL_W'(carry[k]);
      rnext[k] = carry[k] ? NW'(rsum[k] - {1'b0, n_q}) : rsum[k][NW-1:0];
    end
  end

  assign rad_sum = mul_p + 64'd32768;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (accept) begin
      hp_q         <= has_previous_i;
      e_q[FLD_X]   <= {end_x_i[POS_W-1], end_x_i};
      e_q[FLD_Y]   <= {end_y_i[POS_W-1], end_y_i};
      e_q[FLD_P]   <= VAL_W'(ep_sat);
      s_q[FLD_X]   <= has_previous_i ? {start_x_i[POS_W-1], start_x_i}
                                     : {end_x_i[POS_W-1], end_x_i};
      s_q[FLD_Y]   <= has_previous_i ? {start_y_i[POS_W-1], start_y_i}
                                     : {end_y_i[POS_W-1], end_y_i};
      s_q[FLD_P]   <= has_previous_i ? VAL_W'(sp_sat) : VAL_W'(ep_sat);
    end
    unique case (ctrl.phase)
      ST_DY:   d2_q <= prod_q[D2_W-1:0];
      ST_RAD:  d2_q <= d2_q + prod_q[D2_W-1:0];
      ST_RSQ:  rz_q <= (prod_q[MUL_W-1:0] == '0);
      ST_CMP: begin
        n_q     <= n_sel;
        recip_q <= recip_sel;
      end
      ST_MULN: quo_q <= quo_next;
      ST_FIX: begin
        step_q[ctrl.fld]  <= step_new;
        stepr_q[ctrl.fld] <= stepr_new;
        val_q[ctrl.fld]   <= s_q[ctrl.fld];
        accr_q[ctrl.fld]  <= n_q >> 1;
      end
      default: ;
    endcase
    if (ctrl.emit) begin
      for (int k = 0; k < 3; k++) begin
        val_q[k]  <= vnext[k];
        accr_q[k] <= rnext[k];
      end
      out_x_q    <= vnext[FLD_X][POS_W-1:0];
      out_y_q    <= vnext[FLD_Y][POS_W-1:0];
      out_p_q    <= vnext[FLD_P][PRS_W-1:0];
      out_r_q    <= rad_sum[16 +: SIZE_W];
      out_last_q <= sts.last_dab;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (accept) begin
        cnt_q <= '0;
      end else if (ctrl.emit) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (ctrl.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dab_x_o        = out_x_q;
  assign dab_y_o        = out_y_q;
  assign dab_pressure_o = out_p_q;
  assign dab_radius_o   = out_r_q;
  assign last_o         = out_last_q;

endmodule

// ----- verif/stroke_dab_interpolator_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stroke_dab_interpolator_top_tb: self-checking bench for the dab interpolator
// A directed table followed by random segments under several brush sizes,
// with random stalls on both sides and one long output hold-off. Every
// accepted segment that is not pinned is expanded into dabs by a local
// predictor; each dab transaction is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module stroke_dab_interpolator_top_tb;
  import sdi_pkg::*;

  localparam int DAB_MAX         = 16;
  localparam int MID_DABS        = 8;
  localparam int PHASES          = 6;
  localparam int HOLD_PHASE      = 2;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 36;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DIR_N           = 18;

  localparam logic [ADDR_W-1:0] BRUSH_SIZE_ADDR = ADDR_W'(4 * int'(REG_SIZE));

  typedef struct packed {
    logic                    has_prev;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic [PRS_W-1:0]        sp;
    logic signed [POS_W-1:0] ex;
    logic signed [POS_W-1:0] ey;
    logic [PRS_W-1:0]        ep;
  } segment_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [PRS_W-1:0]        p;
    logic [SIZE_W-1:0]       r;
    logic                    last;
  } dab_t;

  typedef struct packed {
    segment_t seg;
    logic     pinned;
    dab_t     dab;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    has_previous_i = 1'b0;
  logic signed [POS_W-1:0] start_x_i = '0;
  logic signed [POS_W-1:0] start_y_i = '0;
  logic [PRS_W-1:0]        start_pressure_i = '0;
  logic signed [POS_W-1:0] end_x_i = '0;
  logic signed [POS_W-1:0] end_y_i = '0;
  logic [PRS_W-1:0]        end_pressure_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [POS_W-1:0] dab_x_o;
  logic signed [POS_W-1:0] dab_y_o;
  logic [PRS_W-1:0]        dab_pressure_o;
  logic [SIZE_W-1:0]       dab_radius_o;
  logic                    last_o;

  logic rx_want = 1'b0;
  logic rx_hold = 1'b0;
  logic hold_go = 1'b0;

  int unsigned tx_gap_max = 7;
  int unsigned rx_gap_max = 7;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  logic              tx_pinned = 1'b0;
  dab_t              tx_pin_dab = '0;
  logic [SIZE_W-1:0] size_shadow = SIZE_RESET;
  dab_t              pending_dabs [$];

  dir_row_t dir_rows [DIR_N] = '{
    '{'{1'b0, 24'sd0, 24'sd0, 17'd0, 24'sd0, 24'sd0, 17'd0},
      1'b1, '{24'sd0, 24'sd0, 17'd0, 14'd0, 1'b1}},
    '{'{1'b0, 24'h7FFFFF, 24'h800000, 17'h1FFFF, 24'h7FFFFF, 24'h800000, 17'd65536},
      1'b1, '{24'h7FFFFF, 24'h800000, 17'd65536, 14'd160, 1'b1}},
    '{'{1'b0, 24'h800000, 24'h7FFFFF, 17'd0, 24'h800000, 24'h7FFFFF, 17'h1FFFF},
      1'b1, '{24'h800000, 24'h7FFFFF, 17'd65536, 14'd160, 1'b1}},
    '{'{1'b0, 24'sd5, 24'sd5, 17'd5, 24'sd12345, -24'sd54321, 17'd65537},
      1'b1, '{24'sd12345, -24'sd54321, 17'd65536, 14'd160, 1'b1}},
    '{'{1'b0, 24'sd0, 24'sd0, 17'd0, -24'sd77, 24'sd77, 17'd1},
      1'b1, '{-24'sd77, 24'sd77, 17'd1, 14'd0, 1'b1}},
    '{'{1'b1, 24'sd1000, -24'sd1000, 17'd65536, 24'sd1000, -24'sd1000, 17'd65536},
      1'b1, '{24'sd1000, -24'sd1000, 17'd65536, 14'd160, 1'b1}},
    '{'{1'b1, -24'sd1, -24'sd1, 17'd0, -24'sd1, -24'sd1, 17'd0},
      1'b1, '{-24'sd1, -24'sd1, 17'd0, 14'd0, 1'b1}},
    '{'{1'b1, 24'sd0, 24'sd0, 17'd0, 24'sd256, 24'sd0, 17'd65536}, 1'b0, '0},
    '{'{1'b1, 24'sd0, 24'sd0, 17'd65536, 24'sd0, 24'sd1, 17'd0}, 1'b0, '0},
    '{'{1'b1, 24'h800000, 24'h800000, 17'd65536, 24'h7FFFFF, 24'h7FFFFF, 17'd65536},
      1'b0, '0},
    '{'{1'b1, 24'sd0, 24'sd0, 17'd65536, 24'sd2560, 24'sd0, 17'd65536}, 1'b0, '0},
    '{'{1'b1, 24'sd0, 24'sd0, 17'd65536, 24'sd2559, 24'sd0, 17'd65536}, 1'b0, '0},
    '{'{1'b1, 24'sd100, -24'sd300, 17'd65536, 24'sd100, 24'sd4820, 17'd65536}, 1'b0, '0},
    '{'{1'b1, 24'sd0, 24'sd0, 17'd65536, -24'sd5119, 24'sd0, 17'd65536}, 1'b0, '0},
    '{'{1'b1, 24'sd0, 24'sd0, 17'h1FFFF, -24'sd3000, 24'sd1000, 17'd65537}, 1'b0, '0},
    '{'{1'b1, -24'sd2563, -24'sd7, 17'd65536, -24'sd3, -24'sd6, 17'd32769}, 1'b0, '0},
    '{'{1'b1, 24'sd5, 24'sd5, 17'd65536, 24'sd4000, -24'sd4000, 17'd1}, 1'b0, '0},
    '{'{1'b1, 24'h7FFFFF, 24'sd0, 17'd40000, 24'h800000, 24'sd0, 17'd20000}, 1'b0, '0}
  };

  assign out_ready_i = rx_want & ~rx_hold;

  stroke_dab_interpolator_top #(
    .MAX_DABS(DAB_MAX)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .has_previous_i  (has_previous_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .start_pressure_i(start_pressure_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .end_pressure_i  (end_pressure_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dab_x_o         (dab_x_o),
    .dab_y_o         (dab_y_o),
    .dab_pressure_o  (dab_pressure_o),
    .dab_radius_o    (dab_radius_o),
    .last_o          (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [SIZE_W-1:0] radius_for(logic [PRS_W-1:0] p,
                                                   logic [SIZE_W-1:0] brush);
    logic [63:0] prod;
    prod = 64'(brush) * 64'(p) + 64'd32768;
    return SIZE_W'(prod >> 16);
  endfunction

  function automatic longint blend(longint a, longint b, longint k, longint n);
    longint offset;
    offset = 64'sh2000000;
    return (a * (n - k) + b * k + n / 2 + offset * n) / n - offset;
  endfunction

  function automatic void expand_segment(segment_t s, logic [SIZE_W-1:0] brush);
    longint      sx, sy, ex, ey, sp, ep, dx, dy, n, k;
    logic [63:0] d2, r, r2;
    dab_t        d;
    sx = longint'(s.sx);
    sy = longint'(s.sy);
    ex = longint'(s.ex);
    ey = longint'(s.ey);
    sp = (s.sp > P_ONE) ? P_ONE : s.sp;
    ep = (s.ep > P_ONE) ? P_ONE : s.ep;
    if (!s.has_prev) begin
      d.x    = POS_W'(ex);
      d.y    = POS_W'(ey);
      d.p    = PRS_W'(ep);
      d.r    = radius_for(PRS_W'(ep), brush);
      d.last = 1'b1;
      pending_dabs.push_back(d);
      return;
    end
    dx = ex - sx;
    dy = ey - sy;
    d2 = 64'(dx * dx + dy * dy);
    r  = 64'(brush) * 64'((sp < ep) ? sp : ep);
    if (r == 0) begin
      n = (d2 != 0) ? DAB_MAX : 1;
    end else begin
      r2 = r * r;
      if (d2 >= ((4 * r2 + 64'hFFFFFF) >> 24)) begin
        n = DAB_MAX;
      end else if (d2 >= ((r2 + 64'hFFFFFF) >> 24)) begin
        n = MID_DABS;
      end else begin
        n = 1;
      end
    end
    for (k = 1; k <= n; k++) begin
      d.x    = POS_W'(blend(sx, ex, k, n));
      d.y    = POS_W'(blend(sy, ey, k, n));
      d.p    = PRS_W'(blend(sp, ep, k, n));
      d.r    = radius_for(d.p, brush);
      d.last = (k == n);
      pending_dabs.push_back(d);
    end
  endfunction

  function automatic void compare_dab(dab_t want, dab_t got);
    if (got.x !== want.x) begin
      $error("dab_x expected %0d got %0d", want.x, got.x);
      fail_count++;
    end
    if (got.y !== want.y) begin
      $error("dab_y expected %0d got %0d", want.y, got.y);
      fail_count++;
    end
    if (got.p !== want.p) begin
      $error("dab_pressure expected %0d got %0d", want.p, got.p);
      fail_count++;
    end
    if (got.r !== want.r) begin
      $error("dab_radius expected %0d got %0d", want.r, got.r);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last expected %0d got %0d", want.last, got.last);
      fail_count++;
    end
  endfunction

  function automatic logic [POS_W-1:0] random_coord();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic longint random_offset(int unsigned span);
    longint v;
    v = longint'($urandom_range(0, span));
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  function automatic logic [PRS_W-1:0] random_pressure();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return P_ONE;
      2: return PRS_W'($urandom_range(65537, 131071));
      default: return PRS_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic segment_t random_segment();
    segment_t    s;
    int unsigned span;
    s.has_prev = ($urandom_range(0, 7) != 0);
    s.sx       = random_coord();
    s.sy       = random_coord();
    case ($urandom_range(0, 4))
      0: span = 0;
      1: span = 1023;
      2: span = 8191;
      3: span = 65535;
      default: span = 24'hFFFFFF;
    endcase
    s.ex = POS_W'(longint'(s.sx) + random_offset(span));
    s.ey = POS_W'(longint'(s.sy) + random_offset(span));
    s.sp = random_pressure();
    s.ep = random_pressure();
    return s;
  endfunction

  task automatic offer_segment(segment_t s, logic pinned, dab_t pin);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    repeat (gap) @(negedge clk_i) in_valid_i <= 1'b0;
    @(negedge clk_i);
    tx_pinned        = pinned;
    tx_pin_dab       = pin;
    in_valid_i       <= 1'b1;
    has_previous_i   <= s.has_prev;
    start_x_i        <= s.sx;
    start_y_i        <= s.sy;
    start_pressure_i <= s.sp;
    end_x_i          <= s.ex;
    end_y_i          <= s.ey;
    end_pressure_i   <= s.ep;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  task automatic write_brush_size(logic [SIZE_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BRUSH_SIZE_ADDR;
    pwdata  <= DATA_W'(value);
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DATA_W'(value)) begin
      $error("brush_size readback expected %0d got %0d", value, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_dabs.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    dab_t     got;
    segment_t seg;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == BRUSH_SIZE_ADDR) begin
        size_shadow = pwdata[SIZE_W-1:0];
      end
      if (out_valid_o && out_ready_i) begin
        got = '{dab_x_o, dab_y_o, dab_pressure_o, dab_radius_o, last_o};
        if (pending_dabs.size() == 0) begin
          $error("dab transaction with nothing expected: x %0d y %0d", got.x, got.y);
          fail_count++;
        end else begin
          compare_dab(pending_dabs.pop_front(), got);
        end
      end
      if (in_valid_i && in_ready_o) begin
        seg = '{has_previous_i, start_x_i, start_y_i, start_pressure_i,
                end_x_i, end_y_i, end_pressure_i};
        if (tx_pinned) begin
          pending_dabs.push_back(tx_pin_dab);
        end else begin
          expand_segment(seg, size_shadow);
        end
      end
    end
  end

  initial begin : receiver
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, rx_gap_max);
      repeat (gap) @(negedge clk_i) rx_want <= 1'b0;
      @(negedge clk_i) rx_want <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  initial begin : output_hold_off
    wait (hold_go);
    @(negedge clk_i) rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [SIZE_W-1:0] brush;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[k]) begin
      offer_segment(dir_rows[k].seg, dir_rows[k].pinned, dir_rows[k].dab);
    end
    @(negedge clk_i) in_valid_i <= 1'b0;
    wait_drained();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: brush = 14'd16;
        1: brush = 14'd16000;
        2: brush = 14'd0;
        3: brush = 14'd16383;
        4: brush = 14'd1;
        default: brush = SIZE_W'($urandom_range(16, 16000));
      endcase
      write_brush_size(brush);
      tx_gap_max = (ph == 1 || ph == 4) ? 0 : 7;
      rx_gap_max = (ph == 1) ? 0 : 7;
      if (ph == HOLD_PHASE) begin
        hold_go = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) offer_segment(random_segment(), 1'b0, '0);
      @(negedge clk_i) in_valid_i <= 1'b0;
      wait_drained();
    end
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_dabs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
